// ===== rtl/core/cbdp_pkg.sv =====
// shared types and constants for the codebook weight dot product
package cbdp_pkg;

  localparam int CODEBOOK_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF    = 16;
  localparam int SUM_WIDTH_DEF      = 48;
  localparam int IDX_WIDTH          = 8;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_MAC   = 1'b1
  } req_type_e;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } mac_ctl_t;

endpackage

// ===== rtl/core/cbdp_ram.sv =====
// generic single-write, single-read ram with registered read data
module cbdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cbdp_mac.sv =====
// multiply stage, accumulator and output word register
module cbdp_mac #(
  parameter int VALUE_WIDTH = cbdp_pkg::VALUE_WIDTH_DEF,
  parameter int SUM_WIDTH   = cbdp_pkg::SUM_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cbdp_pkg::mac_ctl_t     ctl_i,
  input  logic [VALUE_WIDTH-1:0] weight_i,
  input  logic [VALUE_WIDTH-1:0] act_i,
  output logic                   adv_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SUM_WIDTH-1:0]   dot_sum_o
);
  import cbdp_pkg::*;

  localparam int PW = 2 * VALUE_WIDTH;
  localparam int EW = (PW > SUM_WIDTH) ? PW : SUM_WIDTH;

  logic                   adv;
  logic signed [VALUE_WIDTH-1:0] w_sel;
  logic signed [PW-1:0]   prod_d, prod_q;
  logic signed [EW-1:0]   prod_ext;
  logic                   s2_valid_q, s2_last_q;
  logic [SUM_WIDTH-1:0]   sum_d, sum_q;
  logic [SUM_WIDTH-1:0]   acc;
  logic                   out_valid_q;
  logic [SUM_WIDTH-1:0]   out_data_q;

  assign adv      = !out_valid_q || out_ready_i;
  assign w_sel    = ctl_i.hit ? $signed(weight_i) : '0;
  assign prod_d   = w_sel * $signed(act_i);
  assign prod_ext = EW'(prod_q);
  assign acc      = sum_q + prod_ext[SUM_WIDTH-1:0];

  always_comb begin
    sum_d = sum_q;
    if (adv && s2_valid_q) begin
      sum_d = s2_last_q ? '0 : acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
    end
    if (adv && s2_valid_q && s2_last_q) begin
      out_data_q <= acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      if (adv) begin
        s2_valid_q  <= ctl_i.valid;
        s2_last_q   <= ctl_i.last;
        out_valid_q <= s2_valid_q && s2_last_q;
      end
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = out_data_q;

endmodule

// ===== rtl/core/codebook_weight_dot_product_top.sv =====
// top level of the codebook weight dot product
//
// Input channel (in_valid_i / in_ready_o) takes one request word per cycle.
// A write word (req_type REQ_WRITE) stores entry_value at entry_index in the
// codebook ram; writes at or above CODEBOOK_DEPTH are dropped. A mac word
// looks up weight_index (zero at or above depth), multiplies by activation and adds
// the product to the running sum. A mac word with last set sends the sum out
// on the output channel (out_valid_o / out_ready_i) and clears the sum.
// Throughput: one word per cycle while the output is not stalled, set by the
// single codebook read port and one multiply-accumulate per cycle.
// A last word reaches dot_sum_o through the ram read register, loaded at the
// taking edge, then the multiply register and the output register.
// A write is visible to a mac word taken in the very next cycle.
// When the receiver stalls, the whole pipe holds and in_ready_o drops while
// a word waits in the output register; ready returns in the cycle it is taken.
// Reset clears the running sum and pipe valids; the codebook is not cleared
// and must be loaded before use.
module codebook_weight_dot_product_top #(
  parameter int CODEBOOK_DEPTH = cbdp_pkg::CODEBOOK_DEPTH_DEF,
  parameter int VALUE_WIDTH    = cbdp_pkg::VALUE_WIDTH_DEF,
  parameter int SUM_WIDTH      = cbdp_pkg::SUM_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [cbdp_pkg::IDX_WIDTH-1:0] entry_index_i,
  input  logic [VALUE_WIDTH-1:0]         entry_value_i,
  input  logic [cbdp_pkg::IDX_WIDTH-1:0] weight_index_i,
  input  logic [VALUE_WIDTH-1:0]         activation_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [SUM_WIDTH-1:0]           dot_sum_o
);
  import cbdp_pkg::*;

  localparam int AW = $clog2(CODEBOOK_DEPTH);
  localparam logic [IDX_WIDTH:0] DEPTH_LIM = (IDX_WIDTH + 1)'(CODEBOOK_DEPTH);

  logic                   adv;
  logic                   accept;
  logic                   is_mac;
  logic                   wr_hit, rd_hit;
  logic                   ram_we;
  logic [VALUE_WIDTH-1:0] rdata;
  mac_ctl_t               s1_ctl_d, s1_ctl_q;
  logic [VALUE_WIDTH-1:0] s1_act_q;

  assign accept = in_valid_i && adv;
  assign is_mac = (req_type_e'(req_type_i) == REQ_MAC);
  assign wr_hit = {1'b0, entry_index_i} < DEPTH_LIM;
  assign rd_hit = {1'b0, weight_index_i} < DEPTH_LIM;
  assign ram_we = accept && !is_mac && wr_hit;

  cbdp_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CODEBOOK_DEPTH)
  ) u_codebook (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i (entry_value_i),
    .re_i    (accept),
    .raddr_i (weight_index_i[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_ctl_d.valid = accept && is_mac;
    s1_ctl_d.last  = last_i;
    s1_ctl_d.hit   = rd_hit;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q <= activation_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (adv) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  cbdp_mac #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (s1_ctl_q),
    .weight_i    (rdata),
    .act_i       (s1_act_q),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dot_sum_o   (dot_sum_o)
  );

  assign in_ready_o = adv;

endmodule
